### rtl/assert_macros.svh
// Assertion macros shared by the line sensor calibration RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsc assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsc assertion failed");

`endif

### rtl/lsc_pkg.sv
// Shared types, codes and constants of the line sensor calibration block.
package lsc_pkg;

    // Number of reflectance channels and the index of the last one.
    localparam int NCH = 6;
    localparam logic [2:0] LAST_CH = 3'(NCH - 1);

    // Normalized level: 0..100 fits seven quotient bits.
    localparam int LEVEL_BITS = 7;
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 7'd100;
    localparam logic [2:0] LAST_STEP = 3'(LEVEL_BITS - 1);

    // Configuration register indexes.
    localparam logic [2:0] REG_INDICATOR_TH = 3'd0;
    localparam logic [2:0] REG_LINE_TH      = 3'd1;
    localparam logic [2:0] REG_JUNCTION     = 3'd2;
    localparam logic [2:0] REG_STOP_NEAR    = 3'd3;
    localparam logic [2:0] REG_STOP_FAR     = 3'd4;
    localparam logic [2:0] REG_AVOID_NEAR   = 3'd5;
    localparam logic [2:0] REG_AVOID_FAR    = 3'd6;

    // Register reset values.
    localparam logic [6:0]  RST_INDICATOR_TH = 7'd40;
    localparam logic [6:0]  RST_LINE_TH      = 7'd55;
    localparam logic [2:0]  RST_JUNCTION     = 3'd5;
    localparam logic [15:0] RST_STOP_NEAR    = 16'd200;
    localparam logic [15:0] RST_STOP_FAR     = 16'd600;
    localparam logic [15:0] RST_AVOID_NEAR   = 16'd300;
    localparam logic [15:0] RST_AVOID_FAR    = 16'd700;

    // Steering status codes.
    localparam logic [2:0] STATUS_STOP     = 3'd0;
    localparam logic [2:0] STATUS_AVOID    = 3'd1;
    localparam logic [2:0] STATUS_NO_LINE  = 3'd2;
    localparam logic [2:0] STATUS_JUNCTION = 3'd3;
    localparam logic [2:0] STATUS_FOLLOW   = 3'd4;

    // Settings used by the decision stage.
    typedef struct packed {
        logic [2:0]  junction;
        logic [15:0] stop_near;
        logic [15:0] stop_far;
        logic [15:0] avoid_near;
        logic [15:0] avoid_far;
    } win_cfg_t;

    // Per-frame summary of the scaled channels.
    typedef struct packed {
        logic [NCH-1:0]    ind_mask;
        logic [NCH-1:0]    line_mask;
        logic [2:0]        count;
        logic signed [3:0] weight;
    } frame_sum_t;

    // Position tap of a channel, leftmost to rightmost.
    function automatic logic signed [3:0] tap_of(input logic [2:0] ch);
        logic signed [3:0] tap;
        unique case (ch)
            3'd0:    tap = -4'sd4;
            3'd1:    tap = -4'sd2;
            3'd2:    tap = -4'sd1;
            3'd3:    tap = 4'sd1;
            3'd4:    tap = 4'sd2;
            3'd5:    tap = 4'sd4;
            default: tap = 4'sd0;
        endcase
        return tap;
    endfunction

endpackage

### rtl/lsc_divider.sv
// Bit-serial restoring divider giving (diff * 100) / den, one quotient bit per cycle.
`include "assert_macros.svh"

module lsc_divider #(
    parameter int SAMPLE_BITS = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               flat,
    input  logic [SAMPLE_BITS-1:0]             diff,
    input  logic [SAMPLE_BITS-1:0]             den,
    output logic                               done,
    output logic [lsc_pkg::LEVEL_BITS-1:0]     level
);
    import lsc_pkg::*;

    localparam int NW = SAMPLE_BITS + LEVEL_BITS;

    logic [NW-1:0]         rem_reg;
    logic [NW-1:0]         div_reg;
    logic [LEVEL_BITS-1:0] quot_reg;
    logic [2:0]            cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  flat_reg;
    logic [NW-1:0]         diff_w;
    logic [NW-1:0]         num;
    logic                  fits;

    // Scale by 100 as 64 + 32 + 4.
    assign diff_w = {{LEVEL_BITS{1'b0}}, diff};
    assign num    = (diff_w << 6) + (diff_w << 5) + (diff_w << 2);
    assign fits   = (rem_reg >= div_reg);

    // Control: seven steps after start, then a one-cycle done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= LAST_STEP;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: compare, subtract and shift the divisor right.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            div_reg  <= {1'b0, den, 6'b0};
            quot_reg <= '0;
            flat_reg <= flat;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - div_reg;
            end
            quot_reg <= {quot_reg[LEVEL_BITS-2:0], fits};
            div_reg  <= div_reg >> 1;
        end
    end

    // A flat channel has no span and scales to zero.
    assign done  = done_reg;
    assign level = flat_reg ? '0 : quot_reg;

    `LSC_ASSERT_IMPL(a_level_in_range, clk, rst_n, done_reg && !flat_reg,
        quot_reg <= LEVEL_FULL)

endmodule

### rtl/lsc_decide.sv
// Steering decision and the registered result word of the calibration block.
`include "assert_macros.svh"

module lsc_decide (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  lsc_pkg::frame_sum_t sum,
    input  logic [15:0]         distance,
    input  lsc_pkg::win_cfg_t   wcfg,
    output logic                ready,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [5:0]          indicator_mask,
    output logic [5:0]          line_mask,
    output logic [2:0]          line_count,
    output logic [2:0]          status,
    output logic signed [3:0]   position_weight
);
    import lsc_pkg::*;

    logic              out_valid_reg;
    logic [5:0]        ind_reg;
    logic [5:0]        line_reg;
    logic [2:0]        count_reg;
    logic [2:0]        status_reg;
    logic signed [3:0] weight_reg;
    logic              in_stop;
    logic              in_avoid;
    logic [2:0]        status_next;

    // The result register can take a new word once the old one is gone.
    assign ready = !out_valid_reg || !out_stall;

    // Status priority: stop window, avoid window with no line, no line, junction, follow.
    assign in_stop  = (distance >= wcfg.stop_near) && (distance <= wcfg.stop_far);
    assign in_avoid = (distance >= wcfg.avoid_near) && (distance <= wcfg.avoid_far);

    always_comb
    begin
        if (in_stop)
        begin
            status_next = STATUS_STOP;
        end
        else if (sum.count == 3'd0 && in_avoid)
        begin
            status_next = STATUS_AVOID;
        end
        else if (sum.count == 3'd0)
        begin
            status_next = STATUS_NO_LINE;
        end
        else if (sum.count >= wcfg.junction)
        begin
            status_next = STATUS_JUNCTION;
        end
        else
        begin
            status_next = STATUS_FOLLOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word; the weight only counts while following.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ind_reg    <= sum.ind_mask;
            line_reg   <= sum.line_mask;
            count_reg  <= sum.count;
            status_reg <= status_next;
            weight_reg <= (status_next == STATUS_FOLLOW) ? sum.weight : 4'sd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign indicator_mask  = ind_reg;
    assign line_mask       = line_reg;
    assign line_count      = count_reg;
    assign status          = status_reg;
    assign position_weight = weight_reg;

    `LSC_ASSERT_IMPL(a_weight_only_follow, clk, rst_n,
        out_valid_reg && status_reg != STATUS_FOLLOW, weight_reg == 4'sd0)
    `LSC_ASSERT_IMPL(a_count_matches_mask, clk, rst_n, out_valid_reg,
        $countones(line_reg) == int'(count_reg))

endmodule

### rtl/line_sensor_calibrate_and_steer.sv
// Top level of the line sensor calibration and steering block.
// One frame of six reflectance samples and an obstacle distance is taken per
// word; the block widens each channel's running minimum and maximum, scales
// the sample to 0..100 as (sample - min) * 100 / (max - min) truncated (zero
// for a flat channel), and returns the indicator and line masks, the line
// count, a steering status and a position weight. The channels go one after
// another through a single bit-serial divider that yields one quotient bit
// per cycle: each channel passes a setup state and then the divider steps;
// a new frame is taken only once all six channels are done and the result
// is loaded, later while a finished result waits in the output register.
// Input words are stalled while a frame is in work. Configuration must be
// written only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module line_sensor_calibrate_and_steer #(
    parameter int SAMPLE_BITS = 11
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample_0,
    input  logic [SAMPLE_BITS-1:0] sample_1,
    input  logic [SAMPLE_BITS-1:0] sample_2,
    input  logic [SAMPLE_BITS-1:0] sample_3,
    input  logic [SAMPLE_BITS-1:0] sample_4,
    input  logic [SAMPLE_BITS-1:0] sample_5,
    input  logic [15:0]            obstacle_distance,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [5:0]             indicator_mask,
    output logic [5:0]             line_mask,
    output logic [2:0]             line_count,
    output logic [2:0]             status,
    output logic signed [3:0]      position_weight
);
    import lsc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETUP  = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [SAMPLE_BITS-1:0] MIN_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [1:0]             state_reg;
    logic [2:0]             ch_reg;
    logic [SAMPLE_BITS-1:0] samp_reg [NCH];
    logic [SAMPLE_BITS-1:0] min_reg  [NCH];
    logic [SAMPLE_BITS-1:0] max_reg  [NCH];
    logic [15:0]            dist_reg;
    logic [NCH-1:0]         ind_reg;
    logic [NCH-1:0]         line_reg;
    logic [2:0]             count_reg;
    logic signed [3:0]      weight_reg;

    logic [6:0]             ind_th_reg;
    logic [6:0]             line_th_reg;
    win_cfg_t               wcfg_reg;

    logic                   in_accept;
    logic [SAMPLE_BITS-1:0] head_s;
    logic [SAMPLE_BITS-1:0] lo_next;
    logic [SAMPLE_BITS-1:0] hi_next;
    logic                   div_start;
    logic                   div_done;
    logic [LEVEL_BITS-1:0]  level;
    logic                   ind_bit;
    logic                   line_bit;
    logic                   dec_ready;
    logic                   dec_load;
    frame_sum_t             sum;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ind_th_reg          <= RST_INDICATOR_TH;
            line_th_reg         <= RST_LINE_TH;
            wcfg_reg.junction   <= RST_JUNCTION;
            wcfg_reg.stop_near  <= RST_STOP_NEAR;
            wcfg_reg.stop_far   <= RST_STOP_FAR;
            wcfg_reg.avoid_near <= RST_AVOID_NEAR;
            wcfg_reg.avoid_far  <= RST_AVOID_FAR;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INDICATOR_TH: ind_th_reg          <= cfg_data[6:0];
                REG_LINE_TH:      line_th_reg         <= cfg_data[6:0];
                REG_JUNCTION:     wcfg_reg.junction   <= cfg_data[2:0];
                REG_STOP_NEAR:    wcfg_reg.stop_near  <= cfg_data;
                REG_STOP_FAR:     wcfg_reg.stop_far   <= cfg_data;
                REG_AVOID_NEAR:   wcfg_reg.avoid_near <= cfg_data;
                REG_AVOID_FAR:    wcfg_reg.avoid_far  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The head of the rotating channel registers is the channel being set up.
    assign head_s  = samp_reg[0];
    assign lo_next = (head_s < min_reg[0]) ? head_s : min_reg[0];
    assign hi_next = (head_s > max_reg[0]) ? head_s : max_reg[0];

    assign div_start = (state_reg == ST_SETUP);

    lsc_divider #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .flat  (hi_next == lo_next),
        .diff  (head_s - lo_next),
        .den   (hi_next - lo_next),
        .done  (div_done),
        .level (level)
    );

    assign ind_bit  = (level > ind_th_reg);
    assign line_bit = (level < line_th_reg);

    // Running range: rotate one place per channel, writing the widened range at the tail.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                min_reg[i] <= MIN_RESET;
                max_reg[i] <= '0;
            end
        end
        else if (div_start)
        begin
            for (int i = 0; i < NCH - 1; i++)
            begin
                min_reg[i] <= min_reg[i+1];
                max_reg[i] <= max_reg[i+1];
            end
            min_reg[NCH-1] <= lo_next;
            max_reg[NCH-1] <= hi_next;
        end
    end

    // Frame samples and distance; the samples rotate along with the range.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            samp_reg[0] <= sample_0;
            samp_reg[1] <= sample_1;
            samp_reg[2] <= sample_2;
            samp_reg[3] <= sample_3;
            samp_reg[4] <= sample_4;
            samp_reg[5] <= sample_5;
            dist_reg    <= obstacle_distance;
        end
        else if (div_start)
        begin
            for (int i = 0; i < NCH - 1; i++)
            begin
                samp_reg[i] <= samp_reg[i+1];
            end
            samp_reg[NCH-1] <= head_s;
        end
    end

    // Channel sequencer and the per-frame masks, count and weight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ch_reg     <= 3'd0;
            ind_reg    <= '0;
            line_reg   <= '0;
            count_reg  <= 3'd0;
            weight_reg <= 4'sd0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg  <= ST_SETUP;
                        ch_reg     <= 3'd0;
                        ind_reg    <= '0;
                        line_reg   <= '0;
                        count_reg  <= 3'd0;
                        weight_reg <= 4'sd0;
                    end
                end
                ST_SETUP:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        ind_reg  <= {ind_bit, ind_reg[NCH-1:1]};
                        line_reg <= {line_bit, line_reg[NCH-1:1]};
                        if (line_bit)
                        begin
                            count_reg  <= count_reg + 3'd1;
                            weight_reg <= weight_reg + tap_of(ch_reg);
                        end
                        if (ch_reg == LAST_CH)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 3'd1;
                            state_reg <= ST_SETUP;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (dec_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign dec_load      = (state_reg == ST_FINISH) && dec_ready;
    assign sum.ind_mask  = ind_reg;
    assign sum.line_mask = line_reg;
    assign sum.count     = count_reg;
    assign sum.weight    = weight_reg;

    lsc_decide u_decide (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (dec_load),
        .sum             (sum),
        .distance        (dist_reg),
        .wcfg            (wcfg_reg),
        .ready           (dec_ready),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .indicator_mask  (indicator_mask),
        .line_mask       (line_mask),
        .line_count      (line_count),
        .status          (status),
        .position_weight (position_weight)
    );

    `LSC_ASSERT_NEXT(a_accept_starts_frame, clk, rst_n, in_accept,
        state_reg == ST_SETUP && ch_reg == 3'd0)
    `LSC_ASSERT_IMPL(a_channel_in_range, clk, rst_n,
        state_reg == ST_SETUP || state_reg == ST_DIV, ch_reg <= LAST_CH)

endmodule
